// ----- rtl/lf_pkg.sv -----
`timescale 1ns / 1ps
// lf_pkg: shared constants, codes and types for the line follower PD motor drive
// no dependencies; imported by every module and interface of the block

package lf_pkg;

    // frame geometry
    localparam int SENSOR_COUNT  = 8;
    localparam int SAMPLE_BITS   = 12;
    localparam int KIND_BITS     = 2;

    // field widths
    localparam int POS_BITS      = 13;
    localparam int DUTY_BITS     = 8;
    localparam int GAIN_BITS     = 16;
    localparam int BASE_BITS     = 11;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // arithmetic constants
    localparam int POS_STEP      = 1000;
    localparam int POS_MAX       = 8191;
    localparam int DUTY_MAX      = 255;
    localparam int Q_FRAC_BITS   = 12;
    localparam int ERR_BITS      = 14;
    localparam int DERIV_BITS    = 15;

    // PD pipeline sizing
    localparam int PD_STAGES     = 5;
    localparam int PROD_BITS     = GAIN_BITS + DERIV_BITS;
    localparam int PD_BITS       = PROD_BITS + 1;
    localparam int SPD_BITS      = PD_BITS + 1;

    // register reset values
    localparam int PROP_GAIN_RESET  = 41;
    localparam int DERIV_GAIN_RESET = 2048;
    localparam int BASE_SPEED_RESET = 50;
    localparam int TARGET_POS_RESET = 5500;

    // centroid divider sizing
    localparam int CNT_BITS      = $clog2(SENSOR_COUNT + 1);
    localparam int WEIGHT_MAX    = POS_STEP * SENSOR_COUNT * (SENSOR_COUNT - 1) / 2;
    localparam int WEIGHT_BITS   = $clog2(WEIGHT_MAX + 1);
    localparam int DIV_STEP      = 4;
    localparam int DIV_CYCLES    = (WEIGHT_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_BITS      = DIV_CYCLES * DIV_STEP;
    localparam int DIV_ITER_BITS = $clog2(DIV_CYCLES);
    localparam int QEXT_BITS     = (DIV_BITS > POS_BITS) ? DIV_BITS : POS_BITS;

    // frame kinds; the unused code is handled by default arms
    typedef enum logic [KIND_BITS-1:0] {
        KIND_WHITE = 2'd0,
        KIND_BLACK = 2'd1,
        KIND_RUN   = 2'd2
    } t_kind;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_DERIV_GAIN = 2'd1,
        CFG_BASE_SPEED = 2'd2,
        CFG_TARGET_POS = 2'd3
    } t_cfg_idx;

    // top level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_DIV,
        ST_PD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [GAIN_BITS-1:0] prop_gain;
        logic signed [GAIN_BITS-1:0] deriv_gain;
        logic signed [BASE_BITS-1:0] base_speed;
        logic        [POS_BITS-1:0]  target_position;
    } t_cfg;

    typedef struct packed {
        logic wr_white;
        logic wr_black;
        logic run;
    } t_lane_ctrl;

    typedef struct packed {
        logic                done;
        logic                seen;
        logic [POS_BITS-1:0] pos;
    } t_cent;

    typedef struct packed {
        logic                start;
        logic [POS_BITS-1:0] pos;
    } t_pd_req;

    typedef struct packed {
        logic                 done;
        logic [DUTY_BITS-1:0] left_fwd;
        logic [DUTY_BITS-1:0] left_rev;
        logic [DUTY_BITS-1:0] right_fwd;
        logic [DUTY_BITS-1:0] right_rev;
    } t_pd_res;

    typedef struct packed {
        logic [POS_BITS-1:0]  line_position;
        logic                 line_seen;
        logic [DUTY_BITS-1:0] left_forward_duty;
        logic [DUTY_BITS-1:0] left_reverse_duty;
        logic [DUTY_BITS-1:0] right_forward_duty;
        logic [DUTY_BITS-1:0] right_reverse_duty;
    } t_result;

endpackage

// ----- rtl/lf_intf.sv -----
`timescale 1ns / 1ps
// lf_frame_if and lf_result_if: valid/ready channels for sensor frames and drive results
// depends on lf_pkg

interface lf_frame_if import lf_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [KIND_BITS-1:0]   kind;
    logic [SAMPLE_BITS-1:0] sample_0;
    logic [SAMPLE_BITS-1:0] sample_1;
    logic [SAMPLE_BITS-1:0] sample_2;
    logic [SAMPLE_BITS-1:0] sample_3;
    logic [SAMPLE_BITS-1:0] sample_4;
    logic [SAMPLE_BITS-1:0] sample_5;
    logic [SAMPLE_BITS-1:0] sample_6;
    logic [SAMPLE_BITS-1:0] sample_7;

    modport source (
        output valid, kind, sample_0, sample_1, sample_2, sample_3,
               sample_4, sample_5, sample_6, sample_7,
        input  ready
    );
    modport sink (
        input  valid, kind, sample_0, sample_1, sample_2, sample_3,
               sample_4, sample_5, sample_6, sample_7,
        output ready
    );
endinterface

interface lf_result_if import lf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [POS_BITS-1:0]  line_position;
    logic                 line_seen;
    logic [DUTY_BITS-1:0] left_forward_duty;
    logic [DUTY_BITS-1:0] left_reverse_duty;
    logic [DUTY_BITS-1:0] right_forward_duty;
    logic [DUTY_BITS-1:0] right_reverse_duty;

    modport source (
        output valid, line_position, line_seen, left_forward_duty, left_reverse_duty,
               right_forward_duty, right_reverse_duty,
        input  ready
    );
    modport sink (
        input  valid, line_position, line_seen, left_forward_duty, left_reverse_duty,
               right_forward_duty, right_reverse_duty,
        output ready
    );
endinterface

// ----- rtl/lf_lane.sv -----
`timescale 1ns / 1ps
// lf_lane: one sensor lane, holds white and black levels and marks samples above threshold
// depends on lf_pkg

module lf_lane import lf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_lane_ctrl             i_ctrl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_mark
);

    logic [SAMPLE_BITS-1:0] r_white;
    logic [SAMPLE_BITS-1:0] r_black;
    logic                   r_mark;
    logic [SAMPLE_BITS:0]   level_sum;
    logic [SAMPLE_BITS-1:0] threshold;

    // midpoint of the two calibration levels
    assign level_sum = {1'b0, r_white} + {1'b0, r_black};
    assign threshold = level_sum[SAMPLE_BITS:1];

    // calibration levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white <= '0;
            r_black <= '0;
        end else begin
            if (i_ctrl.wr_white) begin
                r_white <= i_sample;
            end
            if (i_ctrl.wr_black) begin
                r_black <= i_sample;
            end
        end
    end

    // mark on run frames
    always_ff @(posedge i_clk) begin
        if (i_ctrl.run) begin
            r_mark <= (i_sample > threshold);
        end
    end

    assign o_mark = r_mark;

endmodule

// ----- rtl/lf_cent.sv -----
`timescale 1ns / 1ps
// lf_cent: merges lane marks into count and weighted sum, then divides for the centroid
// depends on lf_pkg; radix-16 restoring divider, DIV_STEP quotient bits per cycle

module lf_cent import lf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [SENSOR_COUNT-1:0] i_marks,
    output t_cent                   o_cent
);

    logic                     r_busy;
    logic                     r_done;
    logic [DIV_ITER_BITS-1:0] r_iter;
    logic [DIV_BITS-1:0]      r_dvd;
    logic [CNT_BITS-1:0]      r_dsr;
    logic [CNT_BITS-1:0]      r_rem;
    logic                     r_seen;

    logic [DIV_BITS-1:0]      n_dvd;
    logic [CNT_BITS-1:0]      n_rem;
    logic [CNT_BITS:0]        trial;
    logic [CNT_BITS-1:0]      count;
    logic [WEIGHT_BITS-1:0]   weight;
    logic [QEXT_BITS-1:0]     quot_ext;

    // merge: count of marked lanes and sum of their positions
    always_comb begin
        count  = '0;
        weight = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (i_marks[i]) begin
                count  = count + CNT_BITS'(1);
                weight = weight + WEIGHT_BITS'(i * POS_STEP);
            end
        end
    end

    // DIV_STEP restoring steps per cycle; quotient bits shift in at the bottom
    always_comb begin
        n_dvd = r_dvd;
        n_rem = r_rem;
        trial = '0;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial = {n_rem, n_dvd[DIV_BITS-1]};
            n_dvd = n_dvd << 1;
            if (trial >= {1'b0, r_dsr}) begin
                trial    = trial - {1'b0, r_dsr};
                n_dvd[0] = 1'b1;
            end
            n_rem = trial[CNT_BITS-1:0];
        end
    end

    // divider control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= DIV_ITER_BITS'(DIV_CYCLES - 1);
            end else if (r_busy) begin
                r_iter <= r_iter - DIV_ITER_BITS'(1);
                if (r_iter == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= DIV_BITS'(weight);
            r_dsr  <= count;
            r_rem  <= '0;
            r_seen <= |i_marks;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    // saturate the quotient to the position range
    assign quot_ext    = QEXT_BITS'(r_dvd);
    assign o_cent.done = r_done;
    assign o_cent.seen = r_seen;
    assign o_cent.pos  = (quot_ext > QEXT_BITS'(POS_MAX)) ? POS_BITS'(POS_MAX)
                                                          : quot_ext[POS_BITS-1:0];

endmodule

// ----- rtl/lf_pd.sv -----
`timescale 1ns / 1ps
// lf_pd: five-stage PD step from line position to left and right PWM duties
// depends on lf_pkg; keeps the previous error between run frames

module lf_pd import lf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_pd_req i_req,
    output t_pd_res o_res
);

    logic [PD_STAGES-1:0]        r_vld;
    logic signed [ERR_BITS-1:0]  r_prev;
    logic signed [ERR_BITS-1:0]  r_err;
    logic signed [DERIV_BITS-1:0] r_deriv;
    logic signed [PROD_BITS-1:0] r_pprod;
    logic signed [PROD_BITS-1:0] r_dprod;
    logic signed [PD_BITS-1:0]   r_pd;
    logic signed [SPD_BITS-1:0]  r_left_x;
    logic signed [SPD_BITS-1:0]  r_right_x;
    logic [2*DUTY_BITS-1:0]      r_left_duty;
    logic [2*DUTY_BITS-1:0]      r_right_duty;

    logic signed [ERR_BITS-1:0]   err;
    logic signed [DERIV_BITS-1:0] deriv;
    logic signed [PROD_BITS-1:0]  pgain_ext;
    logic signed [PROD_BITS-1:0]  dgain_ext;
    logic signed [PROD_BITS-1:0]  err_ext;
    logic signed [PROD_BITS-1:0]  deriv_ext;
    logic signed [SPD_BITS-1:0]   base_x;

    // truncate a Q.12 speed toward zero, then split into forward and reverse duty
    function automatic logic [2*DUTY_BITS-1:0] split_speed(
        input logic signed [SPD_BITS-1:0] x
    );
        logic signed [SPD_BITS-1:0] q;
        logic [SPD_BITS-1:0]        mag;
        logic [DUTY_BITS-1:0]       fwd;
        logic [DUTY_BITS-1:0]       rev;
        begin
            q = x >>> Q_FRAC_BITS;
            if (x < 0 && x[Q_FRAC_BITS-1:0] != '0) begin
                q = q + SPD_BITS'(1);
            end
            fwd = '0;
            rev = '0;
            if (q < 0) begin
                mag = $unsigned(-q);
                rev = (mag > SPD_BITS'(DUTY_MAX)) ? DUTY_BITS'(DUTY_MAX) : mag[DUTY_BITS-1:0];
            end else begin
                mag = $unsigned(q);
                fwd = (mag > SPD_BITS'(DUTY_MAX)) ? DUTY_BITS'(DUTY_MAX) : mag[DUTY_BITS-1:0];
            end
            return {fwd, rev};
        end
    endfunction

    // error and derivative
    assign err   = $signed({1'b0, i_cfg.target_position}) - $signed({1'b0, i_req.pos});
    assign deriv = DERIV_BITS'(err) - DERIV_BITS'(r_prev);

    // operands extended to product width
    assign pgain_ext = PROD_BITS'(i_cfg.prop_gain);
    assign dgain_ext = PROD_BITS'(i_cfg.deriv_gain);
    assign err_ext   = PROD_BITS'(r_err);
    assign deriv_ext = PROD_BITS'(r_deriv);
    assign base_x    = SPD_BITS'(i_cfg.base_speed) <<< Q_FRAC_BITS;

    // stage valids and previous error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_prev <= '0;
        end else begin
            r_vld <= {r_vld[PD_STAGES-2:0], i_req.start};
            if (i_req.start) begin
                r_prev <= err;
            end
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_err   <= err;
            r_deriv <= deriv;
        end
        r_pprod      <= pgain_ext * err_ext;
        r_dprod      <= dgain_ext * deriv_ext;
        r_pd         <= PD_BITS'(r_pprod) + PD_BITS'(r_dprod);
        r_left_x     <= base_x - SPD_BITS'(r_pd);
        r_right_x    <= base_x + SPD_BITS'(r_pd);
        r_left_duty  <= split_speed(r_left_x);
        r_right_duty <= split_speed(r_right_x);
    end

    assign o_res.done      = r_vld[PD_STAGES-1];
    assign o_res.left_fwd  = r_left_duty[2*DUTY_BITS-1:DUTY_BITS];
    assign o_res.left_rev  = r_left_duty[DUTY_BITS-1:0];
    assign o_res.right_fwd = r_right_duty[2*DUTY_BITS-1:DUTY_BITS];
    assign o_res.right_rev = r_right_duty[DUTY_BITS-1:0];

endmodule

// ----- rtl/line_follow_pd_motor_drive.sv -----
`timescale 1ns / 1ps
// line_follow_pd_motor_drive: top level, sequencer, configuration registers and output register
// depends on lf_pkg, lf_intf, lf_lane, lf_cent, lf_pd

// One frame of eight reflectance samples is taken at a time. White and black calibration
// frames store per-sensor levels and, like frames of the unused kind, load the held position
// with zero duties into the output register once that register is free. A run frame is
// thresholded in eight parallel lanes, merged into a count and weighted sum, divided in a
// radix-16 divider and passed through a five-stage PD pipeline; its result then moves into
// the output register. The next frame is accepted only after the previous result has moved
// into the output register, so no second frame is taken while one is in flight.
// Configuration writes are taken in any cycle and should be made while no frame is in flight.

module line_follow_pd_motor_drive import lf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    lf_frame_if.sink                 i_in,
    lf_result_if.source              o_out,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    t_state              r_state;
    t_state              n_state;
    t_cfg                r_cfg;
    logic [POS_BITS-1:0] r_held;
    logic [POS_BITS-1:0] n_held;
    t_result             r_res;
    t_result             n_res;
    t_result             r_out;
    t_result             n_out;
    logic                r_out_valid;
    logic                n_out_valid;

    t_kind                  in_kind;
    t_lane_ctrl             lane_ctrl;
    logic                   cent_start;
    t_cent                  cent;
    t_pd_req                pd_req;
    t_pd_res                pd_res;
    logic [SENSOR_COUNT-1:0] lane_mark;
    logic [SAMPLE_BITS-1:0] sample [SENSOR_COUNT];

    assign in_kind   = t_kind'(i_in.kind);
    assign sample[0] = i_in.sample_0;
    assign sample[1] = i_in.sample_1;
    assign sample[2] = i_in.sample_2;
    assign sample[3] = i_in.sample_3;
    assign sample[4] = i_in.sample_4;
    assign sample[5] = i_in.sample_5;
    assign sample[6] = i_in.sample_6;
    assign sample[7] = i_in.sample_7;

    // sensor lanes
    for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
        lf_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (lane_ctrl),
            .i_sample (sample[g]),
            .o_mark   (lane_mark[g])
        );
    end

    // merge and centroid divide
    lf_cent u_cent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cent_start),
        .i_marks (lane_mark),
        .o_cent  (cent)
    );

    // PD steering
    lf_pd u_pd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (pd_req),
        .o_res   (pd_res)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain       <= GAIN_BITS'(PROP_GAIN_RESET);
            r_cfg.deriv_gain      <= GAIN_BITS'(DERIV_GAIN_RESET);
            r_cfg.base_speed      <= BASE_BITS'(BASE_SPEED_RESET);
            r_cfg.target_position <= POS_BITS'(TARGET_POS_RESET);
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PROP_GAIN:  r_cfg.prop_gain       <= i_cfg_wdata[GAIN_BITS-1:0];
                CFG_DERIV_GAIN: r_cfg.deriv_gain      <= i_cfg_wdata[GAIN_BITS-1:0];
                CFG_BASE_SPEED: r_cfg.base_speed      <= i_cfg_wdata[BASE_BITS-1:0];
                CFG_TARGET_POS: r_cfg.target_position <= i_cfg_wdata[POS_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer next state and outputs
    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        lane_ctrl   = '0;
        cent_start  = 1'b0;
        pd_req      = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_res               = '0;
                    n_res.line_position = r_held;
                    case (in_kind)
                        KIND_WHITE: begin
                            lane_ctrl.wr_white = 1'b1;
                            n_state            = ST_OUT;
                        end
                        KIND_BLACK: begin
                            lane_ctrl.wr_black = 1'b1;
                            n_state            = ST_OUT;
                        end
                        KIND_RUN: begin
                            lane_ctrl.run = 1'b1;
                            n_state       = ST_MARK;
                        end
                        default: begin
                            n_state = ST_OUT;
                        end
                    endcase
                end
            end
            ST_MARK: begin
                cent_start = 1'b1;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                if (cent.done) begin
                    pd_req.start    = 1'b1;
                    n_res.line_seen = cent.seen;
                    if (cent.seen) begin
                        pd_req.pos          = cent.pos;
                        n_held              = cent.pos;
                        n_res.line_position = cent.pos;
                    end else begin
                        pd_req.pos          = r_held;
                        n_res.line_position = r_held;
                    end
                    n_state = ST_PD;
                end
            end
            ST_PD: begin
                if (pd_res.done) begin
                    n_res.left_forward_duty  = pd_res.left_fwd;
                    n_res.left_reverse_duty  = pd_res.left_rev;
                    n_res.right_forward_duty = pd_res.right_fwd;
                    n_res.right_reverse_duty = pd_res.right_rev;
                    n_state                  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    // result staging and output payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
    end

    assign i_in.ready               = (r_state == ST_IDLE);
    assign o_out.valid              = r_out_valid;
    assign o_out.line_position      = r_out.line_position;
    assign o_out.line_seen          = r_out.line_seen;
    assign o_out.left_forward_duty  = r_out.left_forward_duty;
    assign o_out.left_reverse_duty  = r_out.left_reverse_duty;
    assign o_out.right_forward_duty = r_out.right_forward_duty;
    assign o_out.right_reverse_duty = r_out.right_reverse_duty;

endmodule

// ----- rtl/lf_checker.sv -----
`timescale 1ns / 1ps
// lf_checker: port-level assertions for the line follower drive, bound to the top level
// depends on lf_pkg and line_follow_pd_motor_drive

module lf_checker import lf_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [POS_BITS-1:0]  i_line_position,
    input logic                 i_line_seen,
    input logic [DUTY_BITS-1:0] i_left_fwd,
    input logic [DUTY_BITS-1:0] i_left_rev,
    input logic [DUTY_BITS-1:0] i_right_fwd,
    input logic [DUTY_BITS-1:0] i_right_rev
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_line_position) && $stable(i_line_seen)
            && $stable(i_left_fwd) && $stable(i_left_rev)
            && $stable(i_right_fwd) && $stable(i_right_rev))
        else $error("result payload changed while stalled");

    // one frame in flight: ready drops after each input transaction
    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second frame accepted while one is in flight");

    // a motor never drives forward and reverse at once
    a_duty_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_left_fwd == '0 || i_left_rev == '0)
            && (i_right_fwd == '0 || i_right_rev == '0))
        else $error("forward and reverse duty both nonzero");

endmodule

bind line_follow_pd_motor_drive lf_checker u_lf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_line_position (o_out.line_position),
    .i_line_seen     (o_out.line_seen),
    .i_left_fwd      (o_out.left_forward_duty),
    .i_left_rev      (o_out.left_reverse_duty),
    .i_right_fwd     (o_out.right_forward_duty),
    .i_right_rev     (o_out.right_reverse_duty)
);

// ----- dv/tb_line_follow_pd_motor_drive.sv -----
`timescale 1ns / 1ps
// tb_line_follow_pd_motor_drive: self-checking bench for the line follower PD motor drive
// drives sensor frames and config writes, predicts each drive result and compares it
// depends on lf_pkg, lf_intf and the line_follow_pd_motor_drive top level

module tb_line_follow_pd_motor_drive;
    import lf_pkg::*;

    localparam int                   SAMPLE_TOP   = (1 << SAMPLE_BITS) - 1;
    localparam longint               Q_ONE        = longint'(1) << Q_FRAC_BITS;
    localparam logic [KIND_BITS-1:0] KIND_UNUSED  = 2'd3;
    localparam int                   LONG_HOLD    = 400;
    localparam int                   STALL_LIMIT  = 4000;

    typedef struct packed {
        logic [KIND_BITS-1:0]                        kind;
        logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0]    samples;
    } t_frame;

    // clock, reset and config port
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    t_cfg_idx                 cfg_index   = CFG_PROP_GAIN;
    logic [CFG_DATA_BITS-1:0] cfg_wdata   = '0;

    lf_frame_if  frame_if ();
    lf_result_if drive_if ();

    line_follow_pd_motor_drive u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (frame_if),
        .o_out       (drive_if),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // frame channel driven from registered copies
    t_frame offered_frame = '0;
    logic   frame_valid   = 1'b0;
    logic   drive_ready   = 1'b0;

    assign frame_if.valid    = frame_valid;
    assign frame_if.kind     = offered_frame.kind;
    assign frame_if.sample_0 = offered_frame.samples[0];
    assign frame_if.sample_1 = offered_frame.samples[1];
    assign frame_if.sample_2 = offered_frame.samples[2];
    assign frame_if.sample_3 = offered_frame.samples[3];
    assign frame_if.sample_4 = offered_frame.samples[4];
    assign frame_if.sample_5 = offered_frame.samples[5];
    assign frame_if.sample_6 = offered_frame.samples[6];
    assign frame_if.sample_7 = offered_frame.samples[7];
    assign drive_if.ready    = drive_ready;

    // bench bookkeeping
    t_frame  pending_frames[$];
    t_result expected_drives[$];
    int      frames_sent    = 0;
    int      frames_taken   = 0;
    int      mismatch_count = 0;
    int      src_idle_pct   = 0;
    int      snk_stall_pct  = 0;
    logic    hold_trigger   = 1'b0;
    int      hold_left      = 0;
    int      quiet_cycles   = 0;

    // stimulus-side copy of the calibration levels, used to aim samples at thresholds
    logic [SAMPLE_BITS-1:0] gen_white[SENSOR_COUNT] = '{default: '0};
    logic [SAMPLE_BITS-1:0] gen_black[SENSOR_COUNT] = '{default: '0};

    // predictor state and register copy
    logic [SAMPLE_BITS-1:0]       white_lvl[SENSOR_COUNT] = '{default: '0};
    logic [SAMPLE_BITS-1:0]       black_lvl[SENSOR_COUNT] = '{default: '0};
    logic [POS_BITS-1:0]          held_pos   = '0;
    logic signed [ERR_BITS-1:0]   prev_err   = '0;
    logic signed [GAIN_BITS-1:0]  kp_q12     = GAIN_BITS'(PROP_GAIN_RESET);
    logic signed [GAIN_BITS-1:0]  kd_q12     = GAIN_BITS'(DERIV_GAIN_RESET);
    logic signed [BASE_BITS-1:0]  base_spd   = BASE_BITS'(BASE_SPEED_RESET);
    logic [POS_BITS-1:0]          target_pos = POS_BITS'(TARGET_POS_RESET);

    // magnitude clamp and direction split: {forward, reverse}
    function automatic logic [2*DUTY_BITS-1:0] duty_pair(input longint spd);
        longint mag;
        mag = (spd < 0) ? -spd : spd;
        if (mag > DUTY_MAX)
            mag = DUTY_MAX;
        return (spd < 0) ? {DUTY_BITS'(0), mag[DUTY_BITS-1:0]}
                         : {mag[DUTY_BITS-1:0], DUTY_BITS'(0)};
    endfunction

    // threshold, centroid and PD step for one accepted frame
    function automatic t_result steer_frame(input t_frame f);
        t_result             r;
        int                  cnt;
        int                  wsum;
        int                  thr;
        logic [POS_BITS-1:0] pos;
        longint              err;
        longint              dterm;
        longint              pd;
        r = '0;
        r.line_position = held_pos;
        case (f.kind)
            KIND_WHITE: begin
                for (int i = 0; i < SENSOR_COUNT; i++)
                    white_lvl[i] = f.samples[i];
            end
            KIND_BLACK: begin
                for (int i = 0; i < SENSOR_COUNT; i++)
                    black_lvl[i] = f.samples[i];
            end
            KIND_RUN: begin
                cnt  = 0;
                wsum = 0;
                for (int i = 0; i < SENSOR_COUNT; i++) begin
                    thr = (int'(white_lvl[i]) + int'(black_lvl[i])) >> 1;
                    if (int'(f.samples[i]) > thr) begin
                        cnt++;
                        wsum += i * POS_STEP;
                    end
                end
                // line lost keeps the last seen position
                if (cnt != 0) begin
                    pos      = POS_BITS'((wsum / cnt > POS_MAX) ? POS_MAX : wsum / cnt);
                    held_pos = pos;
                end else begin
                    pos = held_pos;
                end
                err      = longint'(target_pos) - longint'(pos);
                dterm    = err - longint'(prev_err);
                prev_err = ERR_BITS'(err);
                pd       = longint'(kp_q12) * err + longint'(kd_q12) * dterm;
                r.line_position = pos;
                r.line_seen     = (cnt != 0);
                {r.left_forward_duty, r.left_reverse_duty} =
                    duty_pair((longint'(base_spd) * Q_ONE - pd) / Q_ONE);
                {r.right_forward_duty, r.right_reverse_duty} =
                    duty_pair((longint'(base_spd) * Q_ONE + pd) / Q_ONE);
            end
            default: ;
        endcase
        return r;
    endfunction

    // frame driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_valid <= 1'b0;
        end else if (!frame_valid || frame_if.ready) begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                offered_frame <= pending_frames.pop_front();
                frame_valid   <= 1'b1;
            end else begin
                frame_valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and an optional long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drive_ready <= 1'b0;
            hold_left   <= 0;
        end else if (hold_trigger) begin
            drive_ready <= 1'b0;
            hold_left   <= LONG_HOLD;
        end else if (hold_left != 0) begin
            drive_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else begin
            drive_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // monitor: check each result transaction, then predict the new frame
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (drive_if.valid && drive_ready) begin
                got = {drive_if.line_position, drive_if.line_seen,
                       drive_if.left_forward_duty, drive_if.left_reverse_duty,
                       drive_if.right_forward_duty, drive_if.right_reverse_duty};
                if (expected_drives.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: pos=%0d seen=%0d duty=%0d/%0d %0d/%0d",
                                 got.line_position, got.line_seen,
                                 got.left_forward_duty, got.left_reverse_duty,
                                 got.right_forward_duty, got.right_reverse_duty);
                end else begin
                    want = expected_drives.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: exp pos=%0d seen=%0d duty=%0d/%0d %0d/%0d,",
                                      " got pos=%0d seen=%0d duty=%0d/%0d %0d/%0d"},
                                     want.line_position, want.line_seen,
                                     want.left_forward_duty, want.left_reverse_duty,
                                     want.right_forward_duty, want.right_reverse_duty,
                                     got.line_position, got.line_seen,
                                     got.left_forward_duty, got.left_reverse_duty,
                                     got.right_forward_duty, got.right_reverse_duty);
                    end
                end
            end
            if (frame_valid && frame_if.ready) begin
                expected_drives.push_back(steer_frame(offered_frame));
                frames_taken++;
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (frame_valid && frame_if.ready) || (drive_if.valid && drive_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_frame(input t_frame f);
        pending_frames.push_back(f);
        frames_sent++;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (f.kind == KIND_WHITE)
                gen_white[i] = f.samples[i];
            else if (f.kind == KIND_BLACK)
                gen_black[i] = f.samples[i];
        end
    endtask

    task automatic queue_uniform(input logic [KIND_BITS-1:0] kind, input int value);
        t_frame f;
        f.kind = kind;
        for (int i = 0; i < SENSOR_COUNT; i++)
            f.samples[i] = SAMPLE_BITS'(value);
        queue_frame(f);
    endtask

    // run frame whose marked sensors follow the mask, often right at the threshold
    task automatic queue_run_mask(input logic [SENSOR_COUNT-1:0] mask);
        t_frame f;
        int     thr;
        f.kind = KIND_RUN;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            thr = (int'(gen_white[i]) + int'(gen_black[i])) >> 1;
            if (mask[i] && thr < SAMPLE_TOP)
                f.samples[i] = ($urandom_range(7) == 0) ? SAMPLE_BITS'(thr + 1)
                             : SAMPLE_BITS'($urandom_range(SAMPLE_TOP, thr + 1));
            else if (mask[i])
                f.samples[i] = SAMPLE_BITS'(SAMPLE_TOP);
            else
                f.samples[i] = ($urandom_range(7) == 0) ? SAMPLE_BITS'(thr)
                             : SAMPLE_BITS'($urandom_range(thr, 0));
        end
        queue_frame(f);
    endtask

    // mostly line-shaped run frames, some calibration, noise and unused kinds
    task automatic queue_random_frames(input int count);
        t_frame                  f;
        logic [SENSOR_COUNT-1:0] mask;
        int                      pick;
        int                      start;
        int                      width;
        int                      done;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            done++;
            if (pick < 55) begin
                start = $urandom_range(SENSOR_COUNT - 1);
                width = $urandom_range(3, 1);
                mask  = '0;
                for (int i = 0; i < SENSOR_COUNT; i++)
                    mask[i] = (i >= start) && (i < start + width);
                queue_run_mask(mask);
            end else if (pick < 75) begin
                queue_run_mask(SENSOR_COUNT'($urandom));
            end else if (pick < 82) begin
                queue_run_mask('0);
            end else if (pick < 87) begin
                queue_run_mask('1);
            end else begin
                // noise, calibration or unused kind with arbitrary samples
                if (pick < 92)
                    f.kind = KIND_RUN;
                else if (pick < 96)
                    f.kind = ($urandom_range(1) == 0) ? KIND_WHITE : KIND_BLACK;
                else
                    f.kind = KIND_UNUSED;
                for (int i = 0; i < SENSOR_COUNT; i++) begin
                    if (f.kind == KIND_WHITE && $urandom_range(3) != 0)
                        f.samples[i] = SAMPLE_BITS'($urandom_range(2000, 0));
                    else if (f.kind == KIND_BLACK && $urandom_range(3) != 0)
                        f.samples[i] = SAMPLE_BITS'($urandom_range(SAMPLE_TOP, 2000));
                    else
                        f.samples[i] = SAMPLE_BITS'($urandom_range(SAMPLE_TOP));
                end
                if (f.kind == KIND_UNUSED)
                    done--;
                queue_frame(f);
            end
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_PROP_GAIN:  kp_q12     = data;
            CFG_DERIV_GAIN: kd_q12     = data;
            CFG_BASE_SPEED: base_spd   = data[BASE_BITS-1:0];
            CFG_TARGET_POS: target_pos = data[POS_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic write_setting(input int kp, input int kd, input int base, input int target);
        write_reg(CFG_PROP_GAIN,  CFG_DATA_BITS'(kp));
        write_reg(CFG_DERIV_GAIN, CFG_DATA_BITS'(kd));
        write_reg(CFG_BASE_SPEED, CFG_DATA_BITS'(base));
        write_reg(CFG_TARGET_POS, CFG_DATA_BITS'(target));
    endtask

    // wait until every queued frame has been taken and answered
    task automatic drain();
        while (frames_taken != frames_sent || expected_drives.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        t_frame f;
        int     mode;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames at the reset setting, no idling
        queue_uniform(KIND_RUN, 0);               // nothing seen right after reset
        queue_uniform(KIND_RUN, SAMPLE_TOP);      // every sensor on the line
        queue_run_mask(8'h01);
        queue_run_mask(8'h80);
        queue_uniform(KIND_WHITE, SAMPLE_TOP);
        queue_uniform(KIND_BLACK, 0);
        queue_uniform(KIND_RUN, SAMPLE_TOP / 2);  // exactly at threshold is not marked
        queue_uniform(KIND_RUN, SAMPLE_TOP / 2 + 1);
        queue_uniform(KIND_UNUSED, SAMPLE_TOP);   // unused kind leaves state alone
        f.kind = KIND_RUN;
        for (int i = 0; i < SENSOR_COUNT; i++)
            f.samples[i] = (i % 2 == 0) ? 12'haaa : 12'h555;
        queue_frame(f);
        queue_run_mask(8'h06);
        queue_run_mask(8'he0);
        queue_run_mask(8'h00);                    // line lost keeps the last position
        queue_uniform(KIND_BLACK, SAMPLE_TOP);    // threshold at full scale
        queue_uniform(KIND_RUN, SAMPLE_TOP);
        queue_uniform(KIND_UNUSED, 0);
        f.kind = KIND_WHITE;
        for (int i = 0; i < SENSOR_COUNT; i++)
            f.samples[i] = SAMPLE_BITS'(150 * i + 100);
        queue_frame(f);
        f.kind = KIND_BLACK;
        for (int i = 0; i < SENSOR_COUNT; i++)
            f.samples[i] = SAMPLE_BITS'(3900 - 100 * i);
        queue_frame(f);
        queue_run_mask(8'h18);
        queue_run_mask(8'h3c);
        queue_random_frames(240);
        drain();

        // moderate gains, sender mostly idle
        src_idle_pct = 73;
        write_setting(300, 1500, 120, 3500);
        queue_random_frames(260);
        drain();

        // extreme settings, positive proportional gain and base speed, receiver mostly stalled
        src_idle_pct  = 0;
        snk_stall_pct = 73;
        write_setting(32767, -32768, 1023, 7000);
        queue_random_frames(260);
        drain();

        // extreme settings, negative proportional gain and base speed, light idling on both sides
        src_idle_pct  = 9;
        snk_stall_pct = 9;
        write_setting(-32768, 32767, -1023, 0);
        queue_random_frames(260);
        drain();

        // long receiver hold while the sender keeps offering
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        write_setting(-120, 3000, 200, 1000);
        queue_random_frames(260);
        @(posedge i_clk);
        hold_trigger <= 1'b1;
        @(posedge i_clk);
        hold_trigger <= 1'b0;
        drain();

        // random settings under mixed idling
        for (int p = 0; p < 4; p++) begin
            mode = $urandom_range(3);
            src_idle_pct  = (mode == 1) ? 73 : (mode == 3) ? 9 : 0;
            snk_stall_pct = (mode == 2) ? 73 : (mode == 3) ? 9 : 0;
            write_setting(int'($urandom_range(800)) - 400, int'($urandom_range(8192)) - 4096,
                          int'($urandom_range(600)) - 300, int'($urandom_range(7000)));
            queue_random_frames(70);
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && expected_drives.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
